>>> rtl/sli_pkg.sv
// shared types and codes for the sorted list core
package sli_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic ins;       // insert broadcast this cycle
    logic del;       // delete broadcast this cycle
    logic occupied;  // cell holds a live entry
    logic shift;     // cell sits at or after the deleted slot
  } cell_ctrl_t;

endpackage

>>> rtl/sli_if.sv
// request and result channel interfaces
interface sli_in_if;
  logic                               valid;
  logic                               ready;
  logic [sli_pkg::MODE_W-1:0]         mode;
  logic signed [sli_pkg::DATA_W-1:0]  value;
  logic [sli_pkg::POS_W-1:0]          position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface sli_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sli_pkg::DATA_W-1:0]  read_value;
  logic [sli_pkg::STATUS_W-1:0]       status;
  logic [sli_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

>>> rtl/sli_cell.sv
// one slot of the sorted list, shifting with its neighbors
module sli_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  sli_pkg::cell_ctrl_t           ctrl,
  input  logic signed [VALUE_WIDTH-1:0] new_value,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic                          left_lt,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          lt_o
);

  logic signed [VALUE_WIDTH-1:0] value_r;
  logic signed [VALUE_WIDTH-1:0] value_nxt;

  assign value_o = value_r;
  assign lt_o    = ctrl.occupied && (value_r < new_value);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (!lt_o) begin
        value_nxt = left_lt ? new_value : left_value;
      end
    end else if (ctrl.del) begin
      if (ctrl.shift) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

>>> rtl/sorted_list_insert_delete_core.sv
// top level of the sorted list core
// Keeps up to CAPACITY signed values in ascending order in a row of cells; every cell
// compares its entry with the request value at once and takes its own, its left or its
// right neighbor's entry or the new value. A request is taken whenever the result register
// is empty or being drained in the same cycle, giving a sustained rate of one request per
// clock while the output is ready; its result is registered and appears in the cycle after
// the transfer. No clearing pass follows reset: entries past the count are never read.
module sorted_list_insert_delete_core #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  sli_in_if.sink         in_if,
  sli_out_if.source      out_if
);

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (CNT_BITS > sli_pkg::POS_W) ? CNT_BITS : sli_pkg::POS_W;
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic signed [sli_pkg::DATA_W-1:0]   read_value_r;
  logic [sli_pkg::STATUS_W-1:0]        status_r;
  logic [sli_pkg::STATUS_W-1:0]        status_nxt;

  logic                          accept;
  logic [63:0]                   val_wide;
  logic signed [VALUE_WIDTH-1:0] new_val;
  logic [CW-1:0]                 pos_ext;
  logic [CW-1:0]                 del_idx;
  logic                          full;
  logic                          pos_ok;
  logic                          ins_ok;
  logic                          del_ok;
  logic                          rd_ok;
  logic [VALUE_WIDTH-1:0]        rd_raw;
  logic [63:0]                   rd_wide;

  logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]           cell_lt;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign val_wide = {{(64 - sli_pkg::DATA_W){in_if.value[sli_pkg::DATA_W-1]}}, in_if.value};
  assign new_val  = val_wide[VALUE_WIDTH-1:0];
  assign pos_ext  = CW'(in_if.position);
  assign del_idx  = pos_ext - CW'(1);

  assign full   = (count_r == CW'(CAPACITY));
  assign pos_ok = (pos_ext != '0) && (pos_ext <= count_r);
  assign ins_ok = accept && (in_if.mode == sli_pkg::MODE_INSERT) && !full;
  assign del_ok = accept && (in_if.mode == sli_pkg::MODE_DELETE) && pos_ok;
  assign rd_ok  = accept && (in_if.mode == sli_pkg::MODE_READ) && pos_ok;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sli_pkg::cell_ctrl_t           ctrl;
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_lt;
    logic signed [VALUE_WIDTH-1:0] right_value;

    assign ctrl.ins      = ins_ok;
    assign ctrl.del      = del_ok;
    assign ctrl.occupied = (CW'(i) < count_r);
    assign ctrl.shift    = (CW'(i) >= del_idx);

    if (i == 0) begin : g_first
      assign left_value = new_val;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_value = cell_val[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_val[i+1];
    end

    sli_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (new_val),
      .left_value  (left_value),
      .left_lt     (left_lt),
      .right_value (right_value),
      .value_o     (cell_val[i]),
      .lt_o        (cell_lt[i])
    );
  end

  assign rd_raw  = cell_val[del_idx[IW-1:0]];
  assign rd_wide = 64'(rd_raw);

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    unique case (in_if.mode)
      sli_pkg::MODE_INSERT: status_nxt = full ? sli_pkg::STATUS_FULL : sli_pkg::STATUS_OK;
      sli_pkg::MODE_DELETE,
      sli_pkg::MODE_READ:   status_nxt = pos_ok ? sli_pkg::STATUS_OK : sli_pkg::STATUS_RANGE;
      default:              status_nxt = sli_pkg::STATUS_RANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded on every request transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= rd_ok ? rd_wide[sli_pkg::DATA_W-1:0] : '0;
      status_r     <= status_nxt;
    end
  end

  logic [sli_pkg::COUNT_W-1:0] count_out_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      count_out_r <= count_nxt[sli_pkg::COUNT_W-1:0];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.read_value  = read_value_r;
  assign out_if.status      = status_r;
  assign out_if.entry_count = count_out_r;

endmodule
